/* sv/pps_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the pure pursuit steering block.
// No dependencies; pps_ctrl, pps_datapath, the top level and the testbench import it.
package pps_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  localparam logic [CfgIdxW-1:0] CfgWheelbase = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSteerGain = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxSteer  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxJump   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxRate   = 3'd4;

  localparam logic [1:0] StatFiltered = 2'd0;
  localparam logic [1:0] StatFirst    = 2'd1;
  localparam logic [1:0] StatHeld     = 2'd2;
  localparam logic [1:0] StatNoTarget = 2'd3;

  localparam logic [4:0] CordicLast = 5'd19;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_SETUP,
    ST_CORDIC,
    ST_GAIN,
    ST_LIMIT,
    ST_COMPARE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       square;
    logic       update;
    logic       setup;
    logic       cordic;
    logic       gain;
    logic       limit;
    logic       compare;
    logic       divide;
    logic       finish;
    logic [4:0] iter;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic no_target;
    logic need_div;
    logic out_busy;
  } stat_t;

  // Arctangent of 2^-i in units of 2^-20 rad.
  function automatic logic [19:0] atan_entry(input logic [4:0] i);
    logic [19:0] r;
    case (i)
      5'd0:  r = 20'd823550;
      5'd1:  r = 20'd486170;
      5'd2:  r = 20'd256879;
      5'd3:  r = 20'd130396;
      5'd4:  r = 20'd65451;
      5'd5:  r = 20'd32757;
      5'd6:  r = 20'd16383;
      5'd7:  r = 20'd8192;
      5'd8:  r = 20'd4096;
      5'd9:  r = 20'd2048;
      5'd10: r = 20'd1024;
      5'd11: r = 20'd512;
      5'd12: r = 20'd256;
      5'd13: r = 20'd128;
      5'd14: r = 20'd64;
      5'd15: r = 20'd32;
      5'd16: r = 20'd16;
      5'd17: r = 20'd8;
      5'd18: r = 20'd4;
      5'd19: r = 20'd2;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/pps_point_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one path point item.
// No dependencies.
interface pps_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_lateral;
  logic signed [15:0] point_forward;
  logic               last_point;
  logic        [19:0] elapsed_us;

  modport source (output valid, point_lateral, point_forward, last_point, elapsed_us,
                  input ready);
  modport sink   (input valid, point_lateral, point_forward, last_point, elapsed_us,
                  output ready);
endinterface

/* sv/pps_result_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one steering result item.
// No dependencies.
interface pps_result_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] steer_angle;
  logic signed [15:0] target_lateral;
  logic signed [15:0] target_forward;
  logic        [1:0]  status;

  modport source (output valid, steer_angle, target_lateral, target_forward, status,
                  input ready);
  modport sink   (input valid, steer_angle, target_lateral, target_forward, status,
                  output ready);
endinterface

/* sv/pps_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the steering block.
// Depends on pps_pkg.
module pps_ctrl
  import pps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_UPDATE;
      ST_UPDATE: state_d = stat_i.last ? ST_SETUP : ST_IDLE;
      ST_SETUP: begin
        if (stat_i.no_target) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_CORDIC;
          cnt_d   = '0;
        end
      end
      ST_CORDIC: begin
        if (cnt_q == CordicLast) state_d = ST_GAIN;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_GAIN:  state_d = ST_LIMIT;
      ST_LIMIT: state_d = ST_COMPARE;
      ST_COMPARE: begin
        if (stat_i.need_div) begin
          state_d = ST_DIVIDE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIVIDE: state_d = ST_FINISH;
      ST_FINISH: if (!stat_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.iter    = cnt_q;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_SQUARE:  cmd_o.square  = 1'b1;
      ST_UPDATE:  cmd_o.update  = 1'b1;
      ST_SETUP:   cmd_o.setup   = 1'b1;
      ST_CORDIC:  cmd_o.cordic  = 1'b1;
      ST_GAIN:    cmd_o.gain    = 1'b1;
      ST_LIMIT:   cmd_o.limit   = 1'b1;
      ST_COMPARE: cmd_o.compare = 1'b1;
      ST_DIVIDE:  cmd_o.divide  = 1'b1;
      ST_FINISH:  cmd_o.finish  = !stat_i.out_busy;
      default:    cmd_o.iter    = cnt_q;
    endcase
  end

endmodule

/* sv/pps_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the steering block: registers, target search, CORDIC,
// gain, slew filter with a reciprocal divide, and the result register.
// Depends on pps_pkg.
module pps_datapath
  import pps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic signed [15:0]  in_lateral_i,
  input  logic signed [15:0]  in_forward_i,
  input  logic                in_last_i,
  input  logic [19:0]         in_us_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [14:0]  out_steer_o,
  output logic signed [15:0]  out_lateral_o,
  output logic signed [15:0]  out_forward_o,
  output logic [1:0]          out_status_o
);

  // Reciprocal of 15625 scaled by 2^43, rounded up.
  localparam logic [29:0] RecipM = 30'd562949954;

  // Configuration registers.
  logic [11:0] wb_q, gain_q;
  logic [13:0] max_steer_q;
  logic [14:0] max_jump_q;
  logic [17:0] max_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q        <= 12'd256;
      gain_q      <= 12'd256;
      max_steer_q <= 14'd8192;
      max_jump_q  <= 15'd4096;
      max_rate_q  <= 18'd32768;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgWheelbase: wb_q        <= cfg_data_i[11:0];
        CfgSteerGain: gain_q      <= cfg_data_i[11:0];
        CfgMaxSteer:  max_steer_q <= cfg_data_i[13:0];
        CfgMaxJump:   max_jump_q  <= cfg_data_i[14:0];
        CfgMaxRate:   max_rate_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Item capture and squares.
  logic signed [15:0] lat_q, fwd_q;
  logic               last_q;
  logic [19:0]        us_q;
  logic [30:0]        sql_q, sqf_q;
  logic signed [31:0] prod_l, prod_f;

  assign prod_l = lat_q * lat_q;
  assign prod_f = fwd_q * fwd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lat_q  <= in_lateral_i;
      fwd_q  <= in_forward_i;
      last_q <= in_last_i;
      us_q   <= (in_us_i < 20'd1000) ? 20'd1000 : in_us_i;
    end
    if (cmd_i.square) begin
      sql_q <= prod_l[30:0];
      sqf_q <= prod_f[30:0];
    end
  end

  // Target search.
  logic signed [15:0] best_lat_q, best_fwd_q, tl_q, tf_q;
  logic [31:0]        best_dsq_q, tdsq_q, dsq;
  logic               have_q, take;
  logic signed [15:0] b_lat, b_fwd;
  logic [31:0]        b_dsq;
  logic               b_have;

  assign dsq    = {1'b0, sql_q} + {1'b0, sqf_q};
  assign take   = (fwd_q > 16'sd0) && (!have_q || dsq > best_dsq_q);
  assign b_lat  = take ? lat_q : best_lat_q;
  assign b_fwd  = take ? fwd_q : best_fwd_q;
  assign b_dsq  = take ? dsq : best_dsq_q;
  assign b_have = take || have_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_lat_q <= '0;
      best_fwd_q <= '0;
      best_dsq_q <= '0;
      have_q     <= 1'b0;
    end else if (cmd_i.update) begin
      if (last_q) begin
        best_lat_q <= '0;
        best_fwd_q <= '0;
        best_dsq_q <= '0;
        have_q     <= 1'b0;
      end else begin
        best_lat_q <= b_lat;
        best_fwd_q <= b_fwd;
        best_dsq_q <= b_dsq;
        have_q     <= b_have;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && last_q) begin
      tl_q   <= b_have ? b_lat : lat_q;
      tf_q   <= b_have ? b_fwd : fwd_q;
      tdsq_q <= b_have ? b_dsq : dsq;
    end
  end

  // Setup: atan argument num / den and the no-target check.
  logic [15:0] abs_tl;
  logic [19:0] wb250;
  logic [35:0] num;
  logic [38:0] den125, den;
  logic        nt_q, zero_q;

  assign abs_tl = tl_q[15] ? 16'(-tl_q) : tl_q;
  assign wb250  = ({8'd0, wb_q} << 8) - ({8'd0, wb_q} << 2) - ({8'd0, wb_q} << 1);
  assign num    = {16'd0, wb250} * {20'd0, abs_tl};
  assign den125 = ({7'd0, tdsq_q} << 7) - ({7'd0, tdsq_q} << 1) - {7'd0, tdsq_q};
  assign den    = (den125 < 39'd131072) ? 39'd131072 : den125;

  // CORDIC vectoring, one micro-rotation per cycle.
  logic signed [41:0] x_q, y_q, dx, dy;
  logic signed [22:0] z_q, tab;

  assign dx  = y_q >>> cmd_i.iter;
  assign dy  = x_q >>> cmd_i.iter;
  assign tab = 23'(atan_entry(cmd_i.iter));

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      x_q    <= 42'(den);
      y_q    <= 42'(num);
      z_q    <= '0;
      nt_q   <= (tdsq_q <= 32'd1);
      zero_q <= (abs_tl == 16'd0) || (wb_q == 12'd0);
    end else if (cmd_i.cordic) begin
      if (!y_q[41]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - tab;
      end
    end
  end

  // Gain, clamp and slew filter.
  logic [21:0]        zc, zr;
  logic [14:0]        raw;
  logic [26:0]        gprod_q;
  logic [19:0]        mag;
  logic [13:0]        mag_c;
  logic signed [15:0] steer_q;
  logic [37:0]        allow_q;

  assign zc    = z_q[22] ? 22'd0 : z_q[21:0];
  assign zr    = zc + 22'd64;
  assign raw   = zero_q ? 15'd0 : zr[21:7];
  assign mag   = 20'((gprod_q + 27'd128) >> 8);
  assign mag_c = (mag > {6'd0, max_steer_q}) ? max_steer_q : mag[13:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain) gprod_q <= {12'd0, raw} * {15'd0, gain_q};
    if (cmd_i.limit) begin
      steer_q <= tl_q[15] ? -$signed({2'b00, mag_c}) : $signed({2'b00, mag_c});
      allow_q <= {20'd0, max_rate_q} * {18'd0, us_q};
    end
  end

  logic signed [14:0] prev_q;
  logic               have_prev_q;
  logic signed [16:0] delta;
  logic [16:0]        ad;
  logic [36:0]        ad_scaled;
  logic               jump, slow;

  assign delta     = 17'(steer_q) - 17'(prev_q);
  assign ad        = delta[16] ? 17'(-delta) : delta;
  assign ad_scaled = 37'(ad * 37'd1000000);
  assign jump      = ad > {2'b00, max_jump_q};
  assign slow      = {1'b0, ad_scaled} > allow_q;

  // The step floor(allow / 10^6) is (allow >> 6) / 15625, taken by the
  // scaled reciprocal. It is exact while the quotient stays below 2^15,
  // which holds whenever the step replaces the difference.
  logic [61:0] recip;

  assign recip = {30'd0, allow_q[37:6]} * {32'd0, RecipM};

  logic signed [15:0] fin_q;
  logic [1:0]         status_q;
  logic               upd_q, div_q, neg_q;
  logic [14:0]        quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      quo_q <= '0;
      neg_q <= delta[16];
      div_q <= 1'b0;
      if (!have_prev_q) begin
        fin_q    <= steer_q;
        status_q <= StatFirst;
        upd_q    <= 1'b1;
      end else if (jump) begin
        fin_q    <= 16'(prev_q);
        status_q <= StatHeld;
        upd_q    <= 1'b0;
      end else begin
        fin_q    <= steer_q;
        status_q <= StatFiltered;
        upd_q    <= 1'b1;
        div_q    <= slow;
      end
    end else if (cmd_i.divide) begin
      quo_q <= recip[57:43];
    end
  end

  // Final value and clamp.
  logic signed [16:0] step_v, fin_v, lim;

  assign step_v = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign fin_v  = div_q ? 17'(prev_q) + step_v : 17'(fin_q);
  assign lim    = $signed({3'b000, max_steer_q});

  logic signed [16:0] clamped;
  assign clamped = (fin_v > lim) ? lim : ((fin_v < -lim) ? -lim : fin_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if (cmd_i.finish && !nt_q && upd_q) begin
      prev_q      <= fin_v[14:0];
      have_prev_q <= 1'b1;
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (nt_q) begin
        out_steer_o   <= '0;
        out_lateral_o <= '0;
        out_forward_o <= '0;
        out_status_o  <= StatNoTarget;
      end else begin
        out_steer_o   <= clamped[14:0];
        out_lateral_o <= tl_q;
        out_forward_o <= tf_q;
        out_status_o  <= status_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.last      = last_q;
  assign stat_o.no_target = (tdsq_q <= 32'd1);
  assign stat_o.need_div  = have_prev_q && !jump && slow;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

/* sv/pure_pursuit_steering.sv */
`timescale 1ns / 1ps
// Top level of the pure pursuit steering block: controller plus datapath.
// Depends on pps_pkg, pps_point_if, pps_result_if, pps_ctrl, pps_datapath.
//
//   Channel   Direction  Carries
//   point_i   in         one path point (lateral, forward, last flag, elapsed us)
//   result_o  out        one steering result per last point
//   cfg_*     in         register writes, index 0..4, no read-back
//
// An ordinary path point goes through capture, square and search update.
// A last point goes on through setup, the 20-step CORDIC, gain, limit and compare,
// adds the reciprocal divide when the slew limit cuts the step, and ends in finish.
// A last point with no target skips the arithmetic and goes from setup to finish.
// Reset clears all control state and the configuration to its defaults.
// A finished result waits in the output register; only the next last point
// stalls behind it, ordinary points are still taken.
module pure_pursuit_steering
  import pps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pps_point_if.sink           point_i,
  pps_result_if.source        result_o
);

  cmd_t  cmd;
  stat_t stat;

  // The sequencer steps one item through search, arctangent and filter.
  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .in_ready_o (point_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the configuration, path state and result register.
  pps_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_lateral_i  (point_i.point_lateral),
    .in_forward_i  (point_i.point_forward),
    .in_last_i     (point_i.last_point),
    .in_us_i       (point_i.elapsed_us),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .out_steer_o   (result_o.steer_angle),
    .out_lateral_o (result_o.target_lateral),
    .out_forward_o (result_o.target_forward),
    .out_status_o  (result_o.status)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pure_pursuit_steering: directed paths, then random paths.
// Depends on pps_pkg, pps_point_if, pps_result_if and the block's RTL.
module tb;
  import pps_pkg::*;

  localparam int HalfPeriod = 10;
  localparam int StallLimit = 20000;  // cycles with no item accepted on either side
  localparam int SettleCycles = 60;   // longer than the slowest last point takes when the output does not stall
  localparam int PhasePoints = 238;
  localparam int NumPhases = 6;
  localparam int HoldLength = 400;

  typedef struct {
    logic signed [14:0] steer;
    logic signed [15:0] lat;
    logic signed [15:0] fwd;
    logic [1:0]         status;
  } steer_res_t;

  typedef struct {
    int         lat;
    int         fwd;
    bit         last;
    int         us;
    bit         typed;
    steer_res_t res;
  } path_row_t;

  localparam longint AtanQ20[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                     8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
                                     4, 2};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pps_point_if pt ();
  pps_result_if rs ();

  pure_pursuit_steering dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .point_i(pt), .result_o(rs)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Model copy of the registers and of the path and filter state.
  longint wheelbase_r, gain_r, max_steer_r, max_jump_r, max_rate_r;
  longint best_lat, best_fwd, best_dsq, prev_steer;
  bit have_cand, have_prev;

  steer_res_t expected_steer[$];
  int errors = 0;
  int points_sent = 0;
  int results_seen = 0;
  int settings_used = 1;
  int snd_idle_pct = 37;
  int rcv_idle_pct = 60;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  path_row_t dir_rows[12];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    errors++;
  endtask

  // Arctangent of num/den in units of 2^-20 rad by 20 vectoring steps.
  function automatic longint atan_q20(input longint num, input longint den);
    longint x, y, z, dx, dy;
    x = den;
    y = num;
    z = 0;
    if (num == 0) return 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanQ20[i];
      end else begin
        x -= dx; y += dy; z -= AtanQ20[i];
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  // Updates the target search with one point; on the last point works out the steering item.
  task automatic steer_for_point(input int lat, input int fwd, input bit last, input int us,
                                 output bit produced, output steer_res_t r);
    longint d, tl, tf, den, num, raw, mag, steer, delta, ad, allow, u;
    d = longint'(lat) * lat + longint'(fwd) * fwd;
    produced = 1'b0;
    r = '{default: '0};
    if (fwd > 0 && (!have_cand || d > best_dsq)) begin
      best_lat = lat; best_fwd = fwd; best_dsq = d; have_cand = 1'b1;
    end
    if (!last) return;
    produced = 1'b1;
    if (have_cand) begin
      tl = best_lat; tf = best_fwd; d = best_dsq;
    end else begin
      tl = lat; tf = fwd;
    end
    have_cand = 1'b0;
    best_lat = 0; best_fwd = 0; best_dsq = 0;
    if (d <= 1) begin
      r.status = StatNoTarget;
      return;
    end
    den = d * 125;
    if (den < 131072) den = 131072;
    num = 250 * wheelbase_r * ((tl < 0) ? -tl : tl);
    raw = (atan_q20(num, den) + 64) >>> 7;
    raw = (raw * gain_r + 128) >>> 8;
    mag = (raw > max_steer_r) ? max_steer_r : raw;
    steer = (tl < 0) ? -mag : mag;
    u = (us < 1000) ? 1000 : us;
    if (!have_prev) begin
      prev_steer = steer;
      have_prev = 1'b1;
      r.status = StatFirst;
    end else begin
      delta = steer - prev_steer;
      ad = (delta < 0) ? -delta : delta;
      if (ad > max_jump_r) begin
        steer = prev_steer;
        r.status = StatHeld;
      end else begin
        allow = max_rate_r * u;
        if (ad * 1000000 > allow) delta = (delta > 0) ? allow / 1000000 : -(allow / 1000000);
        prev_steer += delta;
        steer = prev_steer;
        r.status = StatFiltered;
      end
    end
    if (steer > max_steer_r) steer = max_steer_r;
    if (steer < -max_steer_r) steer = -max_steer_r;
    r.steer = steer[14:0];
    r.lat = tl[15:0];
    r.fwd = tf[15:0];
  endtask

  // Offers one point, waits for the handshake, then records what it should cause.
  task automatic put_point(input int lat, input int fwd, input bit last, input int us,
                           input bit typed, input steer_res_t typed_res);
    bit produced;
    steer_res_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      pt.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt.valid <= 1'b1;
    pt.point_lateral <= lat[15:0];
    pt.point_forward <= fwd[15:0];
    pt.last_point <= last;
    pt.elapsed_us <= us[19:0];
    @(posedge clk_i);
    while (!pt.ready) @(posedge clk_i);
    steer_for_point(lat, fwd, last, us, produced, r);
    if (produced) expected_steer.insert(expected_steer.size(), typed ? typed_res : r);
    points_sent++;
  endtask

  task automatic drain_and_settle();
    pt.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_steer.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes go in back to back; the block is idle whenever this is called.
  task automatic write_regs(input longint vals[5], input bit poke_unused);
    for (int i = 0; i < 5 + (poke_unused ? 3 : 0); i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= i[CfgIdxW-1:0];
      cfg_data_i <= (i < 5) ? vals[i][CfgDataW-1:0] : CfgDataW'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    wheelbase_r = vals[0] & 12'hFFF;
    gain_r = vals[1] & 12'hFFF;
    max_steer_r = vals[2] & 14'h3FFF;
    max_jump_r = vals[3] & 15'h7FFF;
    max_rate_r = vals[4] & 18'h3FFFF;
    settings_used++;
  endtask

  function automatic int pick_elapsed();
    int k;
    k = $urandom_range(9);
    if (k < 6) return $urandom_range(34000, 22000);
    if (k < 8) return $urandom_range(1500);
    return $urandom_range(1000000);
  endfunction

  // One random path: mostly well-formed forward paths, with some without any point ahead
  // and some of raw full-range noise.
  task automatic send_random_path();
    int kind, n, lat, fwd, centre;
    steer_res_t none;
    none = '{default: '0};
    kind = $urandom_range(99);
    n = $urandom_range(6, 1);
    centre = $urandom_range(8000) - 4000;
    for (int i = 0; i < n; i++) begin
      if (kind < 6) begin
        lat = $urandom_range(2000) - 1000;
        fwd = -$urandom_range(3000);
        if (i == n - 1) begin
          lat = $urandom_range(2) - 1;
          fwd = -$urandom_range(1);
        end
      end else if (kind < 20) begin
        lat = $signed(16'($urandom));
        fwd = $signed(16'($urandom));
      end else begin
        lat = centre + $urandom_range(600) - 300 + i * ($urandom_range(200) - 100);
        fwd = 500 + i * 1500 + $urandom_range(18000);
      end
      put_point(lat, fwd, i == n - 1, pick_elapsed(), 1'b0, none);
    end
  endtask

  // Result side: the stall pattern, plus a long hold-off each time one is requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      rs.ready <= 1'b0;
      hold_served <= hold_requests;
      hold_cycles <= HoldLength;
    end else if (hold_cycles > 0) begin
      rs.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rs.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Checks every accepted result against the oldest expectation, and watches for a hang.
  always @(posedge clk_i) begin
    if (rst_ni && rs.valid && rs.ready) begin
      results_seen++;
      if (expected_steer.size() == 0) begin
        report_mismatch("unexpected result, status", rs.status, -1);
      end else begin
        if (rs.steer_angle !== expected_steer[0].steer)
          report_mismatch("steer_angle", rs.steer_angle, expected_steer[0].steer);
        if (rs.target_lateral !== expected_steer[0].lat)
          report_mismatch("target_lateral", rs.target_lateral, expected_steer[0].lat);
        if (rs.target_forward !== expected_steer[0].fwd)
          report_mismatch("target_forward", rs.target_forward, expected_steer[0].fwd);
        if (rs.status !== expected_steer[0].status)
          report_mismatch("status", rs.status, expected_steer[0].status);
        void'(expected_steer.pop_front());
      end
    end
    if ((pt.valid && pt.ready) || (rs.valid && rs.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    longint cfg_sets[NumPhases][5];
    steer_res_t none;
    none = '{default: '0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    pt.valid = 1'b0;
    pt.point_lateral = '0;
    pt.point_forward = '0;
    pt.last_point = 1'b0;
    pt.elapsed_us = '0;
    wheelbase_r = 256; gain_r = 256; max_steer_r = 8192; max_jump_r = 4096;
    max_rate_r = 32768;
    best_lat = 0; best_fwd = 0; best_dsq = 0; prev_steer = 0;
    have_cand = 1'b0; have_prev = 1'b0;

    // Directed paths. Typed rows: the first path after reset with zero lateral passes
    // straight through, and paths with nothing ahead ending at or beside the origin give no target.
    dir_rows = '{
      '{0, 1000, 1, 30000, 1, '{0, 0, 1000, StatFirst}},
      '{0, 0, 1, 0, 1, '{0, 0, 0, StatNoTarget}},
      '{-32768, -32768, 0, 0, 0, none},
      '{32767, 32767, 0, 1048575, 0, none},
      '{5, -1, 1, 0, 0, none},
      '{100, -5, 0, 0, 0, none},
      '{1, 0, 1, 999, 1, '{0, 0, 0, StatNoTarget}},
      '{-2000, 3000, 1, 1000000, 0, none},
      '{30000, 1, 1, 500, 0, none},
      '{300, 400, 0, 0, 0, none},
      '{400, 300, 0, 0, 0, none},
      '{0, -32768, 1, 20000, 0, none}
    };

    cfg_sets = '{
      '{256, 256, 8192, 4096, 32768},
      '{4095, 4095, 12868, 25736, 262143},
      '{0, 0, 0, 0, 0},
      '{1, 4095, 12868, 0, 1},
      '{1024, 300, 4000, 2000, 65536},
      '{2600, 200, 10000, 12000, 100000}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      put_point(dir_rows[i].lat, dir_rows[i].fwd, dir_rows[i].last, dir_rows[i].us,
                dir_rows[i].typed, dir_rows[i].res);
    // A lone point on the lateral axis: nothing lies ahead, so it is its own target.
    put_point(-500, 0, 1, 20000, 1'b0, none);

    for (int ph = 0; ph < NumPhases; ph++) begin
      int start_count;
      bit held, paused;
      drain_and_settle();
      if (ph > 0) write_regs(cfg_sets[ph], ph == 3);
      else if (settings_used == 1) begin
        longint rnd[5];
        rnd = '{$urandom_range(4095), $urandom_range(4095), $urandom_range(12868),
                $urandom_range(25736), $urandom_range(262143)};
        cfg_sets[0] = rnd;
        write_regs(rnd, 1'b0);
      end
      case (ph % 3)
        0: begin snd_idle_pct = 37; rcv_idle_pct = 60; end
        1: begin snd_idle_pct = 60; rcv_idle_pct = 37; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      start_count = points_sent;
      held = 1'b0;
      paused = 1'b0;
      while (points_sent - start_count < PhasePoints) begin
        if (!held && points_sent - start_count > PhasePoints / 3) begin
          // Receiver shuts off for a long stretch while paths keep coming.
          hold_requests++;
          held = 1'b1;
        end
        if (!paused && points_sent - start_count > 2 * PhasePoints / 3) begin
          // Sender waits until every expected item has come out.
          pt.valid <= 1'b0;
          @(posedge clk_i);
          while (expected_steer.size() != 0) @(posedge clk_i);
          paused = 1'b1;
        end
        send_random_path();
      end
    end

    drain_and_settle();
    $display("tb: %0d path points sent, %0d steering items checked", points_sent,
             results_seen);
    $display("tb: %0d register settings used, including all-zero and all-maximum",
             settings_used);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
